[sv/rcpd_pkg.sv]
// ----------------------------------------------------------------------------
// rcpd_pkg
// shared types, widths and constants of the rgb cube palette dither core
// ----------------------------------------------------------------------------
`default_nettype none

package rcpd_pkg;

  // field widths
  localparam int COLOR_W      = 8;
  localparam int INDEX_W      = 12;
  localparam int LEVELS_REG_W = 5;
  localparam int CFG_DATA_W   = 12;

  // cube size limits
  localparam int MAX_LEVELS_DEF = 16;
  localparam logic [LEVELS_REG_W-1:0] LEVELS_MIN   = LEVELS_REG_W'(2);
  localparam logic [LEVELS_REG_W-1:0] LEVELS_RESET = LEVELS_REG_W'(6);
  localparam logic [INDEX_W-1:0]      BACKGROUND_RESET = '0;

  // dither thresholds on the remainder of c*(L-1) mod full scale
  localparam logic [COLOR_W-1:0] DITHER_LOW  = COLOR_W'(64);
  localparam logic [COLOR_W-1:0] DITHER_HIGH = COLOR_W'(192);

  // channel slots
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int NUM_CH   = 3;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_LEVELS     = 1'b0,
    CFG_BACKGROUND = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [INDEX_W-1:0] left_index;
    logic [INDEX_W-1:0] right_index;
  } cell_pair_t;

  // levels below the minimum count as the minimum, above the maximum as the maximum
  function automatic logic [LEVELS_REG_W-1:0] clamp_levels(
    input logic [LEVELS_REG_W-1:0] raw,
    input logic [LEVELS_REG_W-1:0] max_lv
  );
    logic [LEVELS_REG_W-1:0] v;
    v = raw;
    if (raw < LEVELS_MIN) begin
      v = LEVELS_MIN;
    end else if (raw > max_lv) begin
      v = max_lv;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[sv/rcpd_level_split.sv]
// ----------------------------------------------------------------------------
// rcpd_level_split
// splits one scaled channel into a quotient level and its dithered neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module rcpd_level_split #(
  parameter int MAX_LEVELS = rcpd_pkg::MAX_LEVELS_DEF
) (
  input  wire logic [rcpd_pkg::COLOR_W+$clog2(MAX_LEVELS)-1:0] scaled,
  output logic      [$clog2(MAX_LEVELS)-1:0]                   lo,
  output logic      [$clog2(MAX_LEVELS)-1:0]                   hi
);

  localparam int COLOR_W  = rcpd_pkg::COLOR_W;
  localparam int LEVEL_W  = $clog2(MAX_LEVELS);
  localparam int SCALED_W = COLOR_W + LEVEL_W;
  localparam int SUM_W    = SCALED_W + 1;

  logic [SUM_W-1:0]   quot_sum;
  logic [LEVEL_W-1:0] quot;
  logic [LEVEL_W-1:0] quot_inc;
  logic [SUM_W-1:0]   rem_wide;
  logic [COLOR_W-1:0] rem;

  // x / 255 == (x + (x >> 8) + 1) >> 8 for x well below 2^16
  assign quot_sum = SUM_W'(scaled) + SUM_W'(scaled >> COLOR_W) + SUM_W'(1);
  assign quot     = LEVEL_W'(quot_sum >> COLOR_W);
  assign quot_inc = quot + LEVEL_W'(1);

  // remainder x - 255*q, written as x + q - 256*q
  assign rem_wide = SUM_W'(scaled) + SUM_W'(quot) - (SUM_W'(quot) << COLOR_W);
  assign rem      = rem_wide[COLOR_W-1:0];

  always_comb begin
    if (rem < rcpd_pkg::DITHER_LOW) begin
      lo = quot;
      hi = quot;
    end else if (rem >= rcpd_pkg::DITHER_HIGH) begin
      lo = quot_inc;
      hi = quot_inc;
    end else begin
      lo = quot;
      hi = quot_inc;
    end
  end

endmodule

`default_nettype wire

[sv/rgb_cube_palette_dither_core.sv]
// ----------------------------------------------------------------------------
// rgb_cube_palette_dither_core
// rgb pixel to a pair of color cube palette indices with two-cell dither
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while idx_stall is low, set by the four-register pipeline
//   (scale, level split, index products, index sum and swap)
// stall from the result side backs up through stages only as far as needed
// reset: synchronous rst empties the pipeline and loads levels 6, background 0
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_cube_palette_dither_core #(
  parameter int MAX_LEVELS = rcpd_pkg::MAX_LEVELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // pixel channel
  input  wire logic                            pix_valid,
  output logic                                 pix_stall,
  input  wire rcpd_pkg::pixel_t                pix,
  // index pair channel
  output logic                                 idx_valid,
  input  wire logic                            idx_stall,
  output rcpd_pkg::cell_pair_t                 idx,
  // register writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire rcpd_pkg::cfg_reg_t              cfg_index,
  input  wire logic [rcpd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int COLOR_W  = rcpd_pkg::COLOR_W;
  localparam int INDEX_W  = rcpd_pkg::INDEX_W;
  localparam int LREG_W   = rcpd_pkg::LEVELS_REG_W;
  localparam int NUM_CH   = rcpd_pkg::NUM_CH;
  localparam int LEVEL_W  = $clog2(MAX_LEVELS);
  localparam int SCALED_W = COLOR_W + LEVEL_W;
  localparam int LCNT_W   = LEVEL_W + 1;
  localparam int SQ_W     = 2 * LEVEL_W + 1;
  localparam logic [LREG_W-1:0] MAX_LV = LREG_W'(MAX_LEVELS);

  // --------------------------------------------------------------------------
  // configuration: levels are clamped when written, with L-1 and L*L kept
  // alongside so the datapath sees them as plain registers
  // --------------------------------------------------------------------------
  logic [LREG_W-1:0]  lvl_src;
  logic [LREG_W-1:0]  lvl_eff;
  logic [LCNT_W-1:0]  lvl_eff_n;
  logic               lvl_load;
  logic [LCNT_W-1:0]  lvl;
  logic [LEVEL_W-1:0] lvl_m1;
  logic [SQ_W-1:0]    lvl_sq;
  logic [INDEX_W-1:0] background;

  assign cfg_ready = 1'b1;

  always_comb begin
    lvl_load = rst;
    lvl_src  = rst ? rcpd_pkg::LEVELS_RESET : cfg_data[LREG_W-1:0];
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcpd_pkg::CFG_LEVELS:     lvl_load = 1'b1;
        rcpd_pkg::CFG_BACKGROUND: lvl_load = rst;
        default:                  lvl_load = rst;
      endcase
    end
  end

  assign lvl_eff   = rcpd_pkg::clamp_levels(lvl_src, MAX_LV);
  assign lvl_eff_n = lvl_eff[LCNT_W-1:0];

  always_ff @(posedge clk) begin
    if (lvl_load) begin
      lvl    <= lvl_eff_n;
      lvl_m1 <= LEVEL_W'(lvl_eff_n - LCNT_W'(1));
      lvl_sq <= SQ_W'(SQ_W'(lvl_eff_n) * SQ_W'(lvl_eff_n));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      background <= rcpd_pkg::BACKGROUND_RESET;
    end else if (cfg_valid && cfg_ready && cfg_index == rcpd_pkg::CFG_BACKGROUND) begin
      background <= cfg_data[INDEX_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow: a stage moves when it is empty or its successor moves
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid;
  logic adv1, adv2, adv3, adv_out;

  assign adv_out   = !idx_valid || !idx_stall;
  assign adv3      = !s3_valid || adv_out;
  assign adv2      = !s2_valid || adv3;
  assign adv1      = !s1_valid || adv2;
  assign pix_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      idx_valid <= 1'b0;
    end else begin
      if (adv1)    s1_valid  <= pix_valid;
      if (adv2)    s2_valid  <= s1_valid;
      if (adv3)    s3_valid  <= s2_valid;
      if (adv_out) idx_valid <= s3_valid;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: scale each channel by L-1
  // --------------------------------------------------------------------------
  logic [NUM_CH-1:0][COLOR_W-1:0]  chan;
  logic [NUM_CH-1:0][SCALED_W-1:0] s1_scaled;

  assign chan[rcpd_pkg::CH_RED]   = pix.red;
  assign chan[rcpd_pkg::CH_GREEN] = pix.green;
  assign chan[rcpd_pkg::CH_BLUE]  = pix.blue;

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < NUM_CH; i++) begin
        s1_scaled[i] <= SCALED_W'(SCALED_W'(chan[i]) * SCALED_W'(lvl_m1));
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: quotient by full scale and dither choice per channel
  // --------------------------------------------------------------------------
  logic [NUM_CH-1:0][LEVEL_W-1:0] split_lo, split_hi;
  logic [NUM_CH-1:0][LEVEL_W-1:0] s2_lo, s2_hi;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_split
    rcpd_level_split #(
      .MAX_LEVELS(MAX_LEVELS)
    ) u_split (
      .scaled(s1_scaled[g]),
      .lo    (split_lo[g]),
      .hi    (split_hi[g])
    );
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_lo <= split_lo;
      s2_hi <= split_hi;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: index terms r*L*L, g*L and b for both cells
  // --------------------------------------------------------------------------
  logic [INDEX_W-1:0] s3_r_lo, s3_g_lo, s3_b_lo;
  logic [INDEX_W-1:0] s3_r_hi, s3_g_hi, s3_b_hi;

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_r_lo <= INDEX_W'(INDEX_W'(s2_lo[rcpd_pkg::CH_RED]) * INDEX_W'(lvl_sq));
      s3_g_lo <= INDEX_W'(INDEX_W'(s2_lo[rcpd_pkg::CH_GREEN]) * INDEX_W'(lvl));
      s3_b_lo <= INDEX_W'(s2_lo[rcpd_pkg::CH_BLUE]);
      s3_r_hi <= INDEX_W'(INDEX_W'(s2_hi[rcpd_pkg::CH_RED]) * INDEX_W'(lvl_sq));
      s3_g_hi <= INDEX_W'(INDEX_W'(s2_hi[rcpd_pkg::CH_GREEN]) * INDEX_W'(lvl));
      s3_b_hi <= INDEX_W'(s2_hi[rcpd_pkg::CH_BLUE]);
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: sum the terms, trade places of index zero and background
  // --------------------------------------------------------------------------
  logic [INDEX_W-1:0] sum_lo, sum_hi;
  logic [INDEX_W-1:0] swap_lo, swap_hi;

  assign sum_lo = s3_r_lo + s3_g_lo + s3_b_lo;
  assign sum_hi = s3_r_hi + s3_g_hi + s3_b_hi;

  always_comb begin
    swap_lo = sum_lo;
    if (sum_lo == '0) begin
      swap_lo = background;
    end else if (sum_lo == background) begin
      swap_lo = '0;
    end
    swap_hi = sum_hi;
    if (sum_hi == '0) begin
      swap_hi = background;
    end else if (sum_hi == background) begin
      swap_hi = '0;
    end
  end

  // output register holds a stalled result while the earlier stages refill
  always_ff @(posedge clk) begin
    if (adv_out) begin
      idx.left_index  <= swap_lo;
      idx.right_index <= swap_hi;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // the input side stalls only when every stage is full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (s1_valid && s2_valid && s3_valid && idx_valid && idx_stall))
    else $error("pixel side stalled with a bubble in the pipeline");

  // derived level registers agree with the clamped level count
  a_levels_consistent: assert property (@(posedge clk) disable iff (rst)
    (lvl >= LCNT_W'(2)) && (LCNT_W'(lvl_m1) == lvl - LCNT_W'(1))
      && (lvl_sq == SQ_W'(SQ_W'(lvl) * SQ_W'(lvl))))
    else $error("level registers out of step");

  // an item held in stage 3 behind a blocked output is not dropped
  a_stage3_holds: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !adv_out) |=> s3_valid)
    else $error("stage 3 item lost under stall");

endmodule

`default_nettype wire
